// ===== rtl/b64d_pkg.sv =====
// b64d_pkg: shared types, codes and decode helpers for the base64 stream decoder
// no dependencies; used by the top level and the bench

package b64d_pkg;

  // default width of the saturating position and byte counters
  localparam int COUNT_WIDTH_DEF = 32;

  // result queue: one decoded chunk or one end item fits at once
  localparam int RES_FIFO_DEPTH = 4;
  localparam int MAX_RES        = 3;

  // input operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHABET = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_MAX_OUT  = 2'd2;

  // last chunk handling modes
  localparam logic [1:0] LCM_LOOSE  = 2'd0;
  localparam logic [1:0] LCM_STRICT = 2'd1;
  localparam logic [1:0] LCM_STOP   = 2'd2;
  localparam logic [1:0] LCM_RSVD   = 2'd3;

  // final status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR    = 3'd1;
  localparam logic [2:0] ST_UNEXP_PAD   = 3'd2;
  localparam logic [2:0] ST_INCOMP_PAD  = 3'd3;
  localparam logic [2:0] ST_EXTRA_BITS  = 3'd4;
  localparam logic [2:0] ST_BAD_TRAIL   = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PAD    = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  // decoder phase
  typedef enum logic [3:0] {
    PH_GATHER = 4'b0001,
    PH_PAD1   = 4'b0010,
    PH_PADDED = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [31:0] read_count;
    logic        last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) ||
           (c == CH_CR) || (c == CH_SPACE);
  endfunction

  // returns {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = 8'(c - CH_UP_A);
      return {1'b1, d[5:0]};
    end
    if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = 8'(c - CH_LO_A + 8'd26);
      return {1'b1, d[5:0]};
    end
    if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      d = 8'(c - CH_DIG_0 + 8'd52);
      return {1'b1, d[5:0]};
    end
    if (url) begin
      if (c == CH_MINUS) return {1'b1, 6'd62};
      if (c == CH_UNDER) return {1'b1, 6'd63};
    end else begin
      if (c == CH_PLUS)  return {1'b1, 6'd62};
      if (c == CH_SLASH) return {1'b1, 6'd63};
    end
    return {1'b0, d[5:0]};
  endfunction

  function automatic res_t mk_data(input logic [7:0] b, input logic lst);
    res_t r;
    r.kind       = KIND_DATA;
    r.data_byte  = b;
    r.status     = ST_OK;
    r.read_count = 32'd0;
    r.last       = lst;
    return r;
  endfunction

  function automatic res_t mk_status(input logic [2:0] st, input logic [31:0] rc);
    res_t r;
    r.kind       = KIND_STATUS;
    r.data_byte  = 8'd0;
    r.status     = st;
    r.read_count = rc;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/b64d_if.sv =====
// b64d_if: valid/ready channel interfaces for the decoder input and results
// depends on nothing; payload widths follow the decoder's item fields

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] character;

  modport source (output valid, output operation, output character, input ready);
  modport sink   (input valid, input operation, input character, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic [31:0] read_count;
  logic        last;

  modport source (output valid, output kind, output data_byte, output status,
                  output read_count, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input read_count, input last, output ready);
endinterface

// ===== rtl/base64_stream_decoder.sv =====
// base64_stream_decoder: top level, character decode, chunk state and result queue
// depends on b64d_pkg and the channel interfaces in b64d_if.sv

// The decoder takes one character or end item per clock while the result
// queue has room. Each item is decoded against the current chunk state and its
// results (none for most characters, three bytes for a completed chunk, up to
// two bytes plus a status for an end item) are pushed into a four-entry result
// queue that drains one result per cycle while results are taken. Input is
// accepted whenever the queue has room for three results, so a character that
// yields nothing follows in the next cycle even while one result waits.
// Configuration must be written only while idle; the block itself does not
// enforce it.

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  b64d_in_if.sink            in_ch,
  b64d_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CW    = COUNT_WIDTH;
  localparam int LW    = (CW > 32) ? CW : 32;
  localparam int LW1   = LW + 1;
  localparam int DEPTH = b64d_pkg::RES_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_MAX    = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_MAX_M2 = CNT_MAX - CW'(2);
  localparam logic [CNT_W-1:0] ACCEPT_LIMIT = CNT_W'(DEPTH - b64d_pkg::MAX_RES);

  // configuration registers
  logic        alpha_r;
  logic [1:0]  mode_r;
  logic [31:0] max_r;

  // decoder state
  logic [17:0]        sext_r, sext_nxt;
  logic [1:0]         ccount_r, ccount_nxt;
  b64d_pkg::phase_t   phase_r, phase_nxt;
  logic [CW-1:0]      char_pos_r, char_pos_nxt;
  logic [CW-1:0]      read_pos_r, read_pos_nxt;
  logic [CW-1:0]      bytes_r, bytes_nxt;
  logic [2:0]         err_r, err_nxt;

  // result queue
  b64d_pkg::res_t     fifo_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   qcount_r;

  // per item decode
  logic               accept, pop;
  b64d_pkg::phase_t   phase_eff;
  logic [2:0]         err_eff;
  logic [LW-1:0]      bytes_ext, max_ext;
  logic               strict;
  logic [6:0]         sx;
  logic [5:0]         sx_val;
  logic [23:0]        full_v;
  logic [31:0]        part_v;
  logic [3:0]         extra;
  logic [CW-1:0]      char_pos_inc;
  logic               room_short;
  logic               do_partial;
  logic [2:0]         fin_status;
  logic [CW-1:0]      fin_pos;
  b64d_pkg::res_t     res [b64d_pkg::MAX_RES];
  logic [1:0]         n_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 1'b0;
      mode_r  <= b64d_pkg::LCM_LOOSE;
      max_r   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64d_pkg::REG_ALPHABET: alpha_r <= cfg_wdata[0];
        b64d_pkg::REG_MODE:     mode_r  <= cfg_wdata[1:0];
        b64d_pkg::REG_MAX_OUT:  max_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared decode terms
  assign bytes_ext    = LW'(bytes_r);
  assign max_ext      = LW'(max_r);
  assign strict       = (mode_r == b64d_pkg::LCM_STRICT) || (mode_r == b64d_pkg::LCM_RSVD);
  assign sx           = b64d_pkg::sextet_of(in_ch.character, alpha_r);
  assign sx_val       = sx[5:0];
  assign full_v       = {sext_r, sx_val};
  assign part_v       = (ccount_r == 2'd2) ? {2'b00, sext_r, 12'd0} : {8'd0, sext_r, 6'd0};
  assign extra        = (ccount_r == 2'd2) ? sext_r[3:0] : {2'b00, sext_r[1:0]};
  assign char_pos_inc = (char_pos_r == CNT_MAX) ? CNT_MAX : char_pos_r + CW'(1);
  assign room_short   =
    ((LW1'(bytes_ext) + LW1'(1) == LW1'(max_ext)) && (ccount_r == 2'd2)) ||
    ((LW1'(bytes_ext) + LW1'(2) == LW1'(max_ext)) && (ccount_r == 2'd3));

  // limit check that applies before any item
  always_comb begin
    phase_eff = phase_r;
    err_eff   = err_r;
    if (phase_r == b64d_pkg::PH_GATHER && bytes_ext >= max_ext) begin
      phase_eff = b64d_pkg::PH_HALT;
      err_eff   = b64d_pkg::ST_OK;
    end
  end

  // end item: pick the final status and whether partial bytes go out
  always_comb begin
    do_partial = 1'b0;
    fin_status = b64d_pkg::ST_OK;
    fin_pos    = read_pos_r;
    unique case (phase_eff)
      b64d_pkg::PH_HALT: begin
        fin_status = err_eff;
      end
      b64d_pkg::PH_PAD1: begin
        fin_status = (mode_r == b64d_pkg::LCM_STOP) ? b64d_pkg::ST_OK
                                                   : b64d_pkg::ST_INCOMP_PAD;
      end
      b64d_pkg::PH_PADDED: begin
        if (strict && extra != 4'd0) begin
          fin_status = b64d_pkg::ST_EXTRA_BITS;
        end else begin
          do_partial = 1'b1;
          fin_pos    = char_pos_r;
        end
      end
      b64d_pkg::PH_GATHER: begin
        if (ccount_r == 2'd0) begin
          fin_pos = char_pos_r;
        end else if (mode_r == b64d_pkg::LCM_STOP) begin
          fin_status = b64d_pkg::ST_OK;
        end else if (mode_r == b64d_pkg::LCM_LOOSE && ccount_r >= 2'd2) begin
          do_partial = 1'b1;
          fin_pos    = char_pos_r;
        end else begin
          fin_status = b64d_pkg::ST_BAD_TRAIL;
        end
      end
      default: ;
    endcase
  end

  // next state and results of the accepted item
  always_comb begin
    sext_nxt     = sext_r;
    ccount_nxt   = ccount_r;
    phase_nxt    = phase_r;
    char_pos_nxt = char_pos_r;
    read_pos_nxt = read_pos_r;
    bytes_nxt    = bytes_r;
    err_nxt      = err_r;
    n_res        = 2'd0;
    for (int i = 0; i < b64d_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    if (accept) begin
      phase_nxt = phase_eff;
      err_nxt   = err_eff;
      if (in_ch.operation == b64d_pkg::OP_END) begin
        // final results, then the stream state starts over
        if (do_partial && ccount_r == 2'd3) begin
          res[0] = b64d_pkg::mk_data(part_v[23:16], 1'b0);
          res[1] = b64d_pkg::mk_data(part_v[15:8], 1'b0);
          res[2] = b64d_pkg::mk_status(fin_status, 32'(fin_pos));
          n_res  = 2'd3;
        end else if (do_partial) begin
          res[0] = b64d_pkg::mk_data(part_v[23:16], 1'b0);
          res[1] = b64d_pkg::mk_status(fin_status, 32'(fin_pos));
          n_res  = 2'd2;
        end else begin
          res[0] = b64d_pkg::mk_status(fin_status, 32'(fin_pos));
          n_res  = 2'd1;
        end
        sext_nxt     = '0;
        ccount_nxt   = 2'd0;
        phase_nxt    = b64d_pkg::PH_GATHER;
        char_pos_nxt = '0;
        read_pos_nxt = '0;
        bytes_nxt    = '0;
        err_nxt      = b64d_pkg::ST_OK;
      end else begin
        char_pos_nxt = char_pos_inc;
        if (!b64d_pkg::is_space(in_ch.character)) begin
          unique case (phase_eff)
            b64d_pkg::PH_PAD1: begin
              if (in_ch.character == b64d_pkg::CH_PAD) begin
                phase_nxt = b64d_pkg::PH_PADDED;
              end else begin
                phase_nxt = b64d_pkg::PH_HALT;
                err_nxt   = b64d_pkg::ST_UNEXP_PAD;
              end
            end
            b64d_pkg::PH_PADDED: begin
              phase_nxt = b64d_pkg::PH_HALT;
              err_nxt   = b64d_pkg::ST_UNEXP_PAD;
            end
            b64d_pkg::PH_GATHER: begin
              if (in_ch.character == b64d_pkg::CH_PAD) begin
                // padding after two or three sextets
                if (ccount_r < 2'd2) begin
                  phase_nxt = b64d_pkg::PH_HALT;
                  err_nxt   = b64d_pkg::ST_UNEXP_PAD;
                end else begin
                  phase_nxt = (ccount_r == 2'd2) ? b64d_pkg::PH_PAD1 : b64d_pkg::PH_PADDED;
                end
              end else if (!sx[6]) begin
                phase_nxt = b64d_pkg::PH_HALT;
                err_nxt   = b64d_pkg::ST_BAD_CHAR;
              end else if (room_short) begin
                // next chunk would overrun the byte limit
                phase_nxt = b64d_pkg::PH_HALT;
                err_nxt   = b64d_pkg::ST_OK;
              end else if (ccount_r != 2'd3) begin
                sext_nxt   = {sext_r[11:0], sx_val};
                ccount_nxt = ccount_r + 2'd1;
              end else begin
                // full chunk: three bytes out
                res[0]       = b64d_pkg::mk_data(full_v[23:16], 1'b0);
                res[1]       = b64d_pkg::mk_data(full_v[15:8], 1'b0);
                res[2]       = b64d_pkg::mk_data(full_v[7:0], 1'b1);
                n_res        = 2'd3;
                sext_nxt     = '0;
                ccount_nxt   = 2'd0;
                read_pos_nxt = char_pos_inc;
                bytes_nxt    = (bytes_r >= CNT_MAX_M2) ? CNT_MAX : bytes_r + CW'(3);
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sext_r     <= '0;
      ccount_r   <= 2'd0;
      phase_r    <= b64d_pkg::PH_GATHER;
      char_pos_r <= '0;
      read_pos_r <= '0;
      bytes_r    <= '0;
      err_r      <= b64d_pkg::ST_OK;
    end else begin
      sext_r     <= sext_nxt;
      ccount_r   <= ccount_nxt;
      phase_r    <= phase_nxt;
      char_pos_r <= char_pos_nxt;
      read_pos_r <= read_pos_nxt;
      bytes_r    <= bytes_nxt;
      err_r      <= err_nxt;
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < b64d_pkg::MAX_RES; i++) begin
      if (2'(i) < n_res) begin
        fifo_r[wr_ptr_r + PTR_W'(i)] <= res[i];
      end
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcount_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      qcount_r <= qcount_r + CNT_W'(n_res) - CNT_W'(pop);
    end
  end

  // channel outputs
  assign in_ch.ready       = (qcount_r <= ACCEPT_LIMIT);
  assign out_ch.valid      = (qcount_r != '0);
  assign out_ch.kind       = fifo_r[rd_ptr_r].kind;
  assign out_ch.data_byte  = fifo_r[rd_ptr_r].data_byte;
  assign out_ch.status     = fifo_r[rd_ptr_r].status;
  assign out_ch.read_count = fifo_r[rd_ptr_r].read_count;
  assign out_ch.last       = fifo_r[rd_ptr_r].last;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= CNT_W'(DEPTH))
    else $error("result queue over capacity");

  // an accepted item always finds room for its results
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (qcount_r + CNT_W'(n_res) <= CNT_W'(DEPTH)))
    else $error("item accepted without queue room");

  // end item returns the stream state to its start
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.operation == b64d_pkg::OP_END |=>
      phase_r == b64d_pkg::PH_GATHER && ccount_r == 2'd0 &&
      char_pos_r == '0 && bytes_r == '0)
    else $error("state not cleared after end item");

  // a status result always closes its item's run
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == b64d_pkg::KIND_STATUS |-> out_ch.last)
    else $error("status result without last");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for base64_stream_decoder, predicting every result item
// depends on b64d_pkg (rtl/b64d_pkg.sv) and the channel interfaces (rtl/b64d_if.sv)

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import b64d_pkg::*;

  typedef struct {
    logic       op;
    logic [7:0] ch;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // characters waiting to be sent, predicted decoder output
  stream_item_t char_stream[$];
  res_t         predicted_out[$];

  int   queued_items = 0;
  int   items_done   = 0;
  int   results_seen = 0;
  int   mismatches   = 0;
  logic item_taken   = 1'b0;
  res_t seen_res, want_res;

  // register copies
  logic        url_sel;
  logic [1:0]  end_mode;
  logic [31:0] byte_limit;

  // decoder state copy
  logic [17:0] sextets;
  logic [1:0]  sextet_cnt;
  phase_t      dec_phase;
  logic [31:0] char_pos;
  logic [31:0] chunk_pos;
  logic [31:0] bytes_out;
  logic [2:0]  halt_code;

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE;
  endfunction

  // alphabet lookup, -1 when the character is not a symbol
  function automatic int sextet_value(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A);
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 26;
    if (c >= CH_DIG_0 && c <= CH_DIG_9) return int'(c - CH_DIG_0) + 52;
    if (url_sel && c == CH_MINUS) return 62;
    if (url_sel && c == CH_UNDER) return 63;
    if (!url_sel && c == CH_PLUS) return 62;
    if (!url_sel && c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void clear_decode();
    sextets    = '0;
    sextet_cnt = '0;
    dec_phase  = PH_GATHER;
    char_pos   = '0;
    chunk_pos  = '0;
    bytes_out  = '0;
    halt_code  = ST_OK;
  endfunction

  function automatic void push_result(input logic kind, input logic [7:0] b,
                                      input logic [2:0] st, input logic [31:0] rc,
                                      input logic lst);
    res_t r;
    r.kind       = kind;
    r.data_byte  = b;
    r.status     = st;
    r.read_count = rc;
    r.last       = lst;
    predicted_out.push_back(r);
  endfunction

  function automatic void stop_decode(input logic [2:0] code);
    dec_phase = PH_HALT;
    halt_code = code;
  endfunction

  // status item closes the string and clears the state, registers stay
  function automatic void close_run(input logic [2:0] st, input logic [31:0] rc);
    push_result(KIND_STATUS, 8'd0, st, rc, 1'b1);
    clear_decode();
  endfunction

  // bytes of a chunk of two or three sextets
  function automatic void flush_partial();
    if (sextet_cnt == 2'd2) begin
      push_result(KIND_DATA, sextets[11:4], ST_OK, 32'd0, 1'b0);
    end else begin
      push_result(KIND_DATA, sextets[17:10], ST_OK, 32'd0, 1'b0);
      push_result(KIND_DATA, sextets[9:2], ST_OK, 32'd0, 1'b0);
    end
  endfunction

  function automatic void decode_predict(input logic op, input logic [7:0] c);
    logic        strict_end;
    int          sx;
    logic [31:0] room;
    logic [23:0] word;
    strict_end = (end_mode == LCM_STRICT) || (end_mode == LCM_RSVD);
    // byte limit already reached
    if (dec_phase == PH_GATHER && bytes_out >= byte_limit) stop_decode(ST_OK);
    // end of string
    if (op == OP_END) begin
      if (dec_phase == PH_HALT) begin
        close_run(halt_code, chunk_pos);
      end else if (dec_phase == PH_PAD1) begin
        close_run((end_mode == LCM_STOP) ? ST_OK : ST_INCOMP_PAD, chunk_pos);
      end else if (dec_phase == PH_PADDED) begin
        if (strict_end && ((sextet_cnt == 2'd2) ? (sextets[3:0] != 4'd0)
                                                 : (sextets[1:0] != 2'd0))) begin
          close_run(ST_EXTRA_BITS, chunk_pos);
        end else begin
          flush_partial();
          close_run(ST_OK, char_pos);
        end
      end else if (sextet_cnt == 2'd0) begin
        close_run(ST_OK, char_pos);
      end else if (end_mode == LCM_STOP) begin
        close_run(ST_OK, chunk_pos);
      end else if (end_mode == LCM_LOOSE && sextet_cnt >= 2'd2) begin
        flush_partial();
        close_run(ST_OK, char_pos);
      end else begin
        close_run(ST_BAD_TRAIL, chunk_pos);
      end
      return;
    end
    char_pos = sat_add(char_pos, 32'd1);
    if (dec_phase == PH_HALT || is_blank(c)) return;
    // padding phases
    if (dec_phase == PH_PAD1) begin
      if (c == CH_PAD) dec_phase = PH_PADDED;
      else stop_decode(ST_UNEXP_PAD);
      return;
    end
    if (dec_phase == PH_PADDED) begin
      stop_decode(ST_UNEXP_PAD);
      return;
    end
    if (c == CH_PAD) begin
      if (sextet_cnt < 2'd2) stop_decode(ST_UNEXP_PAD);
      else dec_phase = (sextet_cnt == 2'd2) ? PH_PAD1 : PH_PADDED;
      return;
    end
    sx = sextet_value(c);
    if (sx < 0) begin
      stop_decode(ST_BAD_CHAR);
      return;
    end
    // a chunk that would overrun the limit stops the decode cleanly
    room = byte_limit - bytes_out;
    if ((room == 32'd1 && sextet_cnt == 2'd2) || (room == 32'd2 && sextet_cnt == 2'd3)) begin
      stop_decode(ST_OK);
      return;
    end
    if (sextet_cnt < 2'd3) begin
      sextets = {sextets[11:0], 6'(sx)};
      sextet_cnt++;
      return;
    end
    // full chunk, three bytes
    word = {sextets, 6'(sx)};
    push_result(KIND_DATA, word[23:16], ST_OK, 32'd0, 1'b0);
    push_result(KIND_DATA, word[15:8], ST_OK, 32'd0, 1'b0);
    push_result(KIND_DATA, word[7:0], ST_OK, 32'd0, 1'b1);
    sextets    = '0;
    sextet_cnt = '0;
    chunk_pos  = char_pos;
    bytes_out  = sat_add(bytes_out, 32'd3);
  endfunction

  // input driver: new transfer only after the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || item_taken) begin
      if (char_stream.size() != 0 &&
          ((items_done >= 150 && items_done < 230) || $urandom_range(99) >= 18)) begin
        in_ch.valid     <= 1'b1;
        in_ch.operation <= char_stream[0].op;
        in_ch.character <= char_stream[0].ch;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= (results_seen >= 120 && results_seen < 200) ||
                         ($urandom_range(99) >= 18);
  end

  // monitor: predict on each input transfer, then check each result transfer
  always @(posedge clk) begin
    item_taken = rst_n && in_ch.valid && in_ch.ready;
    if (item_taken) begin
      decode_predict(in_ch.operation, in_ch.character);
      void'(char_stream.pop_front());
      items_done++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_res.kind       = out_ch.kind;
      seen_res.data_byte  = out_ch.data_byte;
      seen_res.status     = out_ch.status;
      seen_res.read_count = out_ch.read_count;
      seen_res.last       = out_ch.last;
      results_seen++;
      if (predicted_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind=%0d byte=%02h status=%0d",
                 $realtime, seen_res.kind, seen_res.data_byte, seen_res.status);
        mismatches++;
      end else begin
        want_res = predicted_out.pop_front();
        if (seen_res !== want_res) begin
          $display("%0t: expected kind=%0d byte=%02h status=%0d count=%0d last=%0d",
                   $realtime, want_res.kind, want_res.data_byte, want_res.status,
                   want_res.read_count, want_res.last);
          $display("%0t:      got kind=%0d byte=%02h status=%0d count=%0d last=%0d",
                   $realtime, seen_res.kind, seen_res.data_byte, seen_res.status,
                   seen_res.read_count, seen_res.last);
          mismatches++;
        end
      end
    end
  end

  task automatic push_item(input logic op, input logic [7:0] ch);
    stream_item_t it;
    it.op = op;
    it.ch = ch;
    char_stream.push_back(it);
    queued_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(OP_CHAR, s[i]);
  endtask

  function automatic logic [7:0] symbol_char(input int unsigned s);
    if (s < 26) return 8'(CH_UP_A + s);
    if (s < 52) return 8'(CH_LO_A + s - 26);
    if (s < 62) return 8'(CH_DIG_0 + s - 52);
    if (s == 62) return url_sel ? CH_MINUS : CH_PLUS;
    return url_sel ? CH_UNDER : CH_SLASH;
  endfunction

  // random symbols with sprinkled whitespace and stray bytes
  task automatic push_symbols(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(4))
          0: push_item(OP_CHAR, CH_TAB);
          1: push_item(OP_CHAR, CH_LF);
          2: push_item(OP_CHAR, CH_FF);
          3: push_item(OP_CHAR, CH_CR);
          default: push_item(OP_CHAR, CH_SPACE);
        endcase
      end
      if ($urandom_range(99) < 3) push_item(OP_CHAR, 8'($urandom_range(255)));
      push_item(OP_CHAR, symbol_char($urandom_range(63)));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ALPHABET: url_sel = val[0];
      REG_MODE:     end_mode = val[1:0];
      REG_MAX_OUT:  byte_limit = val;
      default: ;
    endcase
  endtask

  // sender holds off until every predicted result has been seen
  task automatic wait_idle();
    while (char_stream.size() != 0 || predicted_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // watchdog
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int       streams;
    int       nchunks;
    int       pick;
    logic [31:0] limit;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_CHAR;
    in_ch.character = 8'd0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_ALPHABET;
    cfg_wdata       = 32'd0;
    rst_n           = 1'b0;
    url_sel         = 1'b0;
    end_mode        = LCM_LOOSE;
    byte_limit      = 32'hFFFF_FFFF;
    clear_decode();
    streams = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: whitespace, full chunk, loose tails, bad character then ignored input
    push_text("\t+/9z");
    push_item(OP_END, 8'h00);
    push_text("QQ");
    push_item(OP_END, 8'hFF);
    push_text("QUJ");
    push_item(OP_END, 8'h00);
    push_text("Q");
    push_item(OP_END, 8'h00);
    push_item(OP_CHAR, 8'hFF);
    push_item(OP_CHAR, CH_UP_A);
    push_item(OP_END, 8'h00);
    wait_idle();

    // reserved mode acts as strict, nonzero leftover bits
    write_reg(REG_MODE, LCM_RSVD);
    push_text("QR==");
    push_item(OP_END, 8'h00);
    wait_idle();

    // url alphabet, stop mode, limit splits the second chunk
    write_reg(REG_ALPHABET, 32'd1);
    write_reg(REG_MODE, LCM_STOP);
    write_reg(REG_MAX_OUT, 32'd4);
    push_text("-_AAABC");
    push_item(OP_END, 8'h00);
    wait_idle();

    // limit of zero stops at once
    write_reg(REG_MAX_OUT, 32'd0);
    push_item(OP_CHAR, 8'h00);
    push_item(OP_END, 8'h00);
    wait_idle();

    // random strings, mostly well formed, new settings every few strings
    while (queued_items < 360) begin
      if (streams % 6 == 0) begin
        wait_idle();
        pick = $urandom_range(9);
        if (pick <= 5) limit = 32'hFFFF_FFFF;
        else if (pick == 6) limit = 32'd0;
        else if (pick == 7) limit = $urandom;
        else limit = $urandom_range(1, 12);
        write_reg(REG_ALPHABET, 32'($urandom_range(1)));
        write_reg(REG_MODE, 32'($urandom_range(3)));
        write_reg(REG_MAX_OUT, limit);
      end
      nchunks = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(3);
      push_symbols(4 * nchunks);
      case ($urandom_range(7))
        0: ;
        1: begin push_symbols(2); push_text("=="); end
        2: begin push_symbols(3); push_item(OP_CHAR, CH_PAD); end
        3: push_symbols(2);
        4: push_symbols(3);
        5: push_symbols(1);
        6: begin push_symbols(2); push_item(OP_CHAR, CH_PAD); end
        default: begin
          push_symbols($urandom_range(3));
          push_text("==");
          push_symbols(1);
        end
      endcase
      push_item(OP_END, 8'($urandom_range(255)));
      streams++;
    end
    wait_idle();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
